// File: rtl/cla_pkg.sv
// Package for the console line assembler: sizes, character codes, command
// codes and the line buffer access struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cla_pkg;

  // Longest line plus one; a line holds at most MAX_LEN-1 bytes.
  localparam int MAX_LEN = 128;
  localparam int CNT_W   = $clog2(MAX_LEN);
  localparam int ADDR_W  = CNT_W + 1;
  localparam int DEPTH   = 2 * MAX_LEN;
  localparam int IDX_W   = 7;
  localparam int LEN_W   = 7;
  localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;

  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // One write port and one read port per cycle on the line buffers.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

// File: rtl/cla_line_ram.sv
// Ping-pong line buffer storage: both sides in one memory, one write and
// one registered read per cycle. Uses cla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cla_line_ram (
  input  wire logic              clk,
  input  wire cla_pkg::ram_req_t req,
  output logic [7:0]             rdata
);

  logic [7:0] mem [cla_pkg::DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/cla_ctrl.sv
// Line state: fill count, fill side and completed length, updated once per
// accepted item; issues line buffer accesses. Uses cla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cla_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic                      cmd,
  input  wire logic [7:0]                rx_byte,
  input  wire logic [cla_pkg::IDX_W-1:0] read_index,
  output cla_pkg::ram_req_t              req,
  output logic                           line_done,
  output logic [cla_pkg::CNT_W-1:0]      done_len_nxt,
  output logic                           rd_hit
);

  logic [cla_pkg::CNT_W-1:0] fill_count_r, fill_count_nxt;
  logic                      fill_side_r, fill_side_nxt;
  logic [cla_pkg::CNT_W-1:0] done_len_r;
  logic                      is_erase, is_eol, has_room;

  always_comb begin
    is_erase       = (rx_byte == cla_pkg::CH_BS) || (rx_byte == cla_pkg::CH_DEL);
    is_eol         = (rx_byte == cla_pkg::CH_CR) || (rx_byte == cla_pkg::CH_LF);
    has_room       = fill_count_r != cla_pkg::CNT_W'(cla_pkg::MAX_LEN - 1);
    fill_count_nxt = fill_count_r;
    fill_side_nxt  = fill_side_r;
    done_len_nxt   = done_len_r;
    line_done      = 1'b0;
    rd_hit         = 1'b0;
    req.we         = 1'b0;
    req.waddr      = {fill_side_r, fill_count_r};
    req.wdata      = rx_byte;
    req.re         = 1'b0;
    req.raddr      = {~fill_side_r, cla_pkg::CNT_W'(read_index)};

    if (cmd == cla_pkg::CMD_RX) begin
      if (is_erase) begin
        if (fill_count_r != '0) begin
          fill_count_nxt = fill_count_r - 1'b1;
        end
      end else if (is_eol) begin
        if (fill_count_r != '0) begin
          line_done      = 1'b1;
          done_len_nxt   = fill_count_r;
          fill_side_nxt  = ~fill_side_r;
          fill_count_nxt = '0;
        end
      end else if (has_room) begin
        req.we         = accept;
        fill_count_nxt = fill_count_r + 1'b1;
      end
    end else begin
      // Only entries below the completed length belong to the completed line.
      rd_hit = cla_pkg::CMP_W'(read_index) < cla_pkg::CMP_W'(done_len_r);
      req.re = accept && rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      fill_side_r  <= 1'b0;
      done_len_r   <= '0;
    end else if (accept) begin
      fill_count_r <= fill_count_nxt;
      fill_side_r  <= fill_side_nxt;
      done_len_r   <= done_len_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/console_line_assembler.sv
// Console line assembler top level: line state control, line buffer memory
// and the result register. Uses cla_pkg, cla_ctrl, cla_line_ram.
// Results are registered onto the out_ port. Throughput: one item per cycle
// while out_ready does not hold a pending result; the state update and the
// single memory write or registered read all fit in the accepting cycle.
// Reset (synchronous, rst_n low): empty line, fill side 0, completed length
// 0, no result pending. Line buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module console_line_assembler (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic [6:0] in_read_index,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_echo_valid,
  output logic [7:0]      out_echo_byte,
  output logic            out_line_ready,
  output logic [6:0]      out_line_length,
  output logic [7:0]      out_read_byte
);

  logic                          accept;
  cla_pkg::ram_req_t             req;
  logic                          line_done;
  logic [cla_pkg::CNT_W-1:0]     done_len_nxt;
  logic                          rd_hit;
  logic [7:0]                    rdata;

  // Result register; the memory's read register is its read_byte half.
  logic                          out_valid_r;
  logic                          echo_valid_r;
  logic [7:0]                    echo_byte_r;
  logic                          line_ready_r;
  logic [cla_pkg::LEN_W-1:0]     line_length_r;
  logic                          rd_hit_r;

  // A new item enters whenever the result slot is empty or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  cla_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .cmd          (in_cmd),
    .rx_byte      (in_rx_byte),
    .read_index   (in_read_index),
    .req          (req),
    .line_done    (line_done),
    .done_len_nxt (done_len_nxt),
    .rd_hit       (rd_hit)
  );

  cla_line_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload holds while stalled since it only loads on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      echo_valid_r  <= in_cmd == cla_pkg::CMD_RX;
      echo_byte_r   <= (in_cmd == cla_pkg::CMD_RX) ? in_rx_byte : 8'd0;
      line_ready_r  <= line_done;
      line_length_r <= cla_pkg::LEN_W'(done_len_nxt);
      rd_hit_r      <= rd_hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_valid  = echo_valid_r;
  assign out_echo_byte   = echo_byte_r;
  assign out_line_ready  = line_ready_r;
  assign out_line_length = line_length_r;
  // Reads past the line end return the terminator (zero).
  assign out_read_byte   = rd_hit_r ? rdata : 8'd0;

endmodule
`default_nettype wire
